// ===== rtl/forest_leaf_label_probability_assert.svh =====
// Assertion macros shared by the forest leaf probability RTL
`ifndef FOREST_LEAF_LABEL_PROBABILITY_ASSERT_SVH
`define FOREST_LEAF_LABEL_PROBABILITY_ASSERT_SVH
// Check an implication on every clock edge outside reset
`define FLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check an implication on every clock edge, reset included
`define FLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/flp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flp_pkg
// Shared types and constants of the forest leaf label probability block.
// ----------------------------------------------------------------------------
package flp_pkg;
  localparam int unsigned MaxLabelsCap = 8;
  localparam int unsigned LabelBits = 3;
  localparam int unsigned CfgBits = 4;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATIO,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } flp_state_t;

  // Front-to-back control
  typedef struct packed {
    logic final_tree;
  } flp_ctrl_t;
endpackage

// ===== rtl/flp_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flp_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module flp_divider #(
  parameter int unsigned NUM_BITS = 56,
  parameter int unsigned DEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);
  localparam int unsigned CntBits = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q_r, q_nxt;
  logic [DEN_BITS:0]   rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic [CntBits-1:0]  cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [DEN_BITS:0]   trial;

  // Shift in one numerator bit and try a subtract
  always_comb begin
    trial = {rem_r[DEN_BITS-1:0], q_r[NUM_BITS-1]};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = numer;
      rem_nxt = '0;
      cnt_nxt = CntBits'(NUM_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NUM_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntBits'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= denom;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ===== rtl/flp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flp_front
// Two-entry queue that takes leaf records and hands them to the back end.
// ----------------------------------------------------------------------------
module flp_front #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  output logic         avail,
  output logic [W-1:0] rdata,
  input  logic         take
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_take;

  assign full = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign do_push = push && !full;
  assign do_take = take && avail;
  assign rdata = mem_r[rp_r];

  // Advance pointers and count on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_take};
    end
    if (do_push) mem_r[wp_r] <= wdata;
  end
endmodule

// ===== rtl/flp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flp_back
// Ratio, product and normalize sequencer with a one-entry result register.
// ----------------------------------------------------------------------------
module flp_back #(
  parameter int unsigned MAX_LABELS = 8,
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned FRAC_BITS = 23
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   avail,
  input  logic [(MAX_LABELS+1)*COUNT_BITS-1:0]   counts,
  input  logic [COUNT_BITS-1:0]                  total,
  input  flp_pkg::flp_ctrl_t                     ctrl,
  output logic                                   take,
  input  logic [flp_pkg::CfgBits-1:0]            active_labels,
  output logic                                   out_valid,
  input  logic                                   out_pop,
  output logic [flp_pkg::LabelBits-1:0]          label_index,
  output logic [FRAC_BITS:0]                     probability,
  output logic                                   nonzero,
  output logic                                   last_label
);
  import flp_pkg::*;

  localparam int unsigned QBits = FRAC_BITS + 1;
  localparam int unsigned Lanes = MAX_LABELS + 1;
  localparam int unsigned LaneBits = $clog2(Lanes + 1);
  localparam int unsigned SumBits = QBits + 4;
  localparam int unsigned RNum = COUNT_BITS + FRAC_BITS;
  localparam int unsigned PNum = SumBits + FRAC_BITS;
  localparam logic [QBits-1:0] OneQ = QBits'(1) << FRAC_BITS;

  flp_state_t state_r, state_nxt;
  logic [QBits-1:0]     prod_r [Lanes];
  logic [QBits-1:0]     ratio_r;
  logic [LaneBits-1:0]  lane_r;
  logic [SumBits-1:0]   sum_r;
  logic [3:0]           n_r;
  logic                 fin_r;
  logic [2*QBits-1:0]   mul_r;

  // Shared dividers for ratios and normalization
  logic                 rd_start, rd_done, pd_start, pd_done;
  logic [RNum-1:0]      rd_q;
  logic [PNum-1:0]      pd_q;
  logic [COUNT_BITS-1:0] cur_count;
  logic [RNum-1:0]      rd_num;
  logic [QBits-1:0]     rd_sat;
  logic [LaneBits-1:0]  rd_lane, pd_lane;

  // A division started from the multiply or emit step works on the next lane
  assign rd_lane = (state_r == ST_MUL) ? lane_r + 1'b1 : lane_r;
  assign pd_lane = (state_r == ST_SUM) ? LaneBits'(1) : lane_r + 1'b1;

  assign cur_count = counts[rd_lane*COUNT_BITS +: COUNT_BITS];
  assign rd_num = {cur_count, {FRAC_BITS{1'b0}}};
  assign rd_sat = (rd_q > RNum'(OneQ)) ? OneQ : rd_q[QBits-1:0];

  flp_divider #(.NUM_BITS(RNum), .DEN_BITS(COUNT_BITS)) u_rdiv (
    .clk, .rst_n, .start(rd_start), .numer(rd_num), .denom(total),
    .done(rd_done), .quot(rd_q)
  );
  flp_divider #(.NUM_BITS(PNum), .DEN_BITS(SumBits)) u_pdiv (
    .clk, .rst_n, .start(pd_start),
    .numer({(SumBits-QBits)'(0), prod_r[pd_lane], {FRAC_BITS{1'b0}}}),
    .denom(sum_r), .done(pd_done), .quot(pd_q)
  );

  logic out_valid_r;
  logic last_lane;
  logic emit_go;
  assign last_lane = (lane_r == LaneBits'(Lanes - 1));
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_pop);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (avail) state_nxt = ST_RATIO;
      ST_RATIO: if (total == '0 || rd_done) state_nxt = ST_MUL;
      ST_MUL: begin
        if (!last_lane) state_nxt = ST_RATIO;
        else if (fin_r) state_nxt = ST_SUM;
        else state_nxt = ST_IDLE;
      end
      ST_SUM:   if (lane_r == LaneBits'(n_r)) state_nxt = ST_DIV;
      ST_DIV:   if (pd_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_pop) begin
          if (lane_r == LaneBits'(n_r)) state_nxt = ST_IDLE;
          else state_nxt = ST_DIV;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    rd_start = 1'b0;
    pd_start = 1'b0;
    take = 1'b0;
    unique case (state_r)
      ST_IDLE:  rd_start = avail && (total != '0);
      ST_MUL:   rd_start = !last_lane && (total != '0);
      ST_SUM:   pd_start = (lane_r == LaneBits'(n_r));
      ST_EMIT:  pd_start = (!out_valid_r || out_pop) && (lane_r != LaneBits'(n_r));
      default:  ;
    endcase
    take = (state_r == ST_MUL) && last_lane;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      lane_r <= '0;
      for (int k = 0; k < Lanes; k++) prod_r[k] <= OneQ;
      n_r <= 4'd8;
    end else begin
      state_r <= state_nxt;
      // Load the result register on emit, drop it on a transfer
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          lane_r <= '0;
          fin_r <= ctrl.final_tree;
          if (active_labels == '0) n_r <= 4'd1;
          else if (active_labels > 4'(MAX_LABELS)) n_r <= 4'(MAX_LABELS);
          else n_r <= active_labels;
        end
        ST_RATIO: begin
          if (total == '0) mul_r <= '0;
          else if (rd_done) mul_r <= prod_r[lane_r] * rd_sat;
        end
        ST_MUL: begin
          prod_r[lane_r] <= mul_r[FRAC_BITS +: QBits];
          if (last_lane) begin
            lane_r <= '0;
            sum_r <= SumBits'(prod_r[0]) + 1'b1;
          end else lane_r <= lane_r + 1'b1;
        end
        ST_SUM: begin
          // lane 0 holds background; labels sit in lanes 1..n
          if (lane_r != LaneBits'(n_r)) begin
            sum_r <= sum_r + SumBits'(prod_r[lane_r + 1'b1]);
            lane_r <= lane_r + 1'b1;
          end else lane_r <= LaneBits'(1);
        end
        ST_EMIT: begin
          if (emit_go) begin
            label_index <= LabelBits'(lane_r - 1'b1);
            probability <= pd_q[QBits-1:0];
            nonzero <= (pd_q != '0);
            last_label <= (lane_r == LaneBits'(n_r));
            if (lane_r == LaneBits'(n_r)) begin
              for (int k = 0; k < Lanes; k++) prod_r[k] <= OneQ;
              lane_r <= '0;
            end else lane_r <= lane_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  `include "forest_leaf_label_probability_assert.svh"
  `FLP_ASSERT(a_take_idle, take |=> state_r == ST_IDLE || state_r == ST_SUM, "take not at record end")
  `FLP_ASSERT(a_emit_lane, out_valid_r && last_label |-> label_index == LabelBits'(n_r - 1'b1), "last label mismatch")
  `FLP_ASSERT(a_div_state, pd_done |-> state_r == ST_DIV, "normalize done out of place")
endmodule

// ===== rtl/forest_leaf_label_probability.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forest_leaf_label_probability
// Running per-label leaf products across trees, normalized on the last tree.
// ----------------------------------------------------------------------------
//  channel   ports                                handshake
//  input     in_leaf_total .. in_final_tree       push / full
//  result    out_label_index .. out_last_label    pop / empty
//  config    cfg_we, cfg_active_labels            write enable
//
// Each record runs one lane per count: a COUNT_BITS+FRAC_BITS bit division
// of the count by leaf_total, a multiply by the running product and its
// write-back; leaf_total zero skips the division. A final record adds a sum
// pass over background and active labels and one normalize per active label.
// Reset is synchronous; products return to one and active_labels to 8.
// A two-entry queue takes records while the back end works; results stall
// the back end only while the result register is still full.
module forest_leaf_label_probability #(
  parameter int unsigned MAX_LABELS = 8,
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned FRAC_BITS = 23
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [COUNT_BITS-1:0]           in_leaf_total,
  input  logic [COUNT_BITS-1:0]           in_leaf_background,
  input  logic [COUNT_BITS-1:0]           in_class_count_0,
  input  logic [COUNT_BITS-1:0]           in_class_count_1,
  input  logic [COUNT_BITS-1:0]           in_class_count_2,
  input  logic [COUNT_BITS-1:0]           in_class_count_3,
  input  logic [COUNT_BITS-1:0]           in_class_count_4,
  input  logic [COUNT_BITS-1:0]           in_class_count_5,
  input  logic [COUNT_BITS-1:0]           in_class_count_6,
  input  logic [COUNT_BITS-1:0]           in_class_count_7,
  input  logic                            in_final_tree,
  output logic                            empty,
  input  logic                            pop,
  output logic [flp_pkg::LabelBits-1:0]   out_label_index,
  output logic [FRAC_BITS:0]              out_probability,
  output logic                            out_nonzero,
  output logic                            out_last_label,
  input  logic                            cfg_we,
  input  logic [flp_pkg::CfgBits-1:0]     cfg_active_labels
);
  import flp_pkg::*;

  localparam int unsigned CW = (MaxLabelsCap + 2) * COUNT_BITS + 1;
  logic [CW-1:0] wdata, rdata;
  logic          avail, take, out_valid;
  logic [CfgBits-1:0] active_r;
  flp_ctrl_t     ctrl;

  // Hold the label count register
  always_ff @(posedge clk) begin
    if (!rst_n) active_r <= CfgBits'(8);
    else if (cfg_we) active_r <= cfg_active_labels;
  end

  assign wdata = {in_class_count_7, in_class_count_6, in_class_count_5, in_class_count_4,
                  in_class_count_3, in_class_count_2, in_class_count_1, in_class_count_0,
                  in_leaf_background, in_leaf_total, in_final_tree};

  flp_front #(.W(CW)) u_front (
    .clk, .rst_n, .push, .wdata, .full, .avail, .rdata, .take
  );

  assign ctrl.final_tree = rdata[0];

  // Background sits in lane 0, label counts follow in lanes 1..MAX_LABELS
  flp_back #(.MAX_LABELS(MAX_LABELS), .COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .avail,
    .counts(rdata[COUNT_BITS+1 +: (MAX_LABELS+1)*COUNT_BITS]),
    .total(rdata[1 +: COUNT_BITS]), .ctrl, .take,
    .active_labels(active_r), .out_valid, .out_pop(pop),
    .label_index(out_label_index), .probability(out_probability),
    .nonzero(out_nonzero), .last_label(out_last_label)
  );

  assign empty = !out_valid;
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the forest leaf label probability block: leaf records are pushed
// through its input queue, a local predictor tracks the running background
// and label products, and every popped result is compared field by field
// with the oldest expected label probability.
// ----------------------------------------------------------------------------
module tb_top;
  import flp_pkg::*;

  localparam int unsigned NumLabels = 8;
  localparam int unsigned FracBits = 23;
  localparam logic [23:0] OneQ = 24'h800000;
  localparam logic [23:0] CountMax = 24'hFFFFFF;
  localparam int unsigned RecordCycles = 600;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    logic [23:0] total;
    logic [23:0] background;
    logic [23:0] counts [NumLabels];
    logic        final_tree;
  } leaf_record_t;

  typedef struct packed {
    logic [LabelBits-1:0] label_index;
    logic [23:0]          probability;
    logic                 nonzero;
    logic                 last_label;
  } label_prob_t;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic [23:0] in_leaf_total;
  logic [23:0] in_leaf_background;
  logic [23:0] in_class_count [NumLabels];
  logic in_final_tree;
  logic empty;
  logic pop;
  logic [LabelBits-1:0] out_label_index;
  logic [23:0] out_probability;
  logic out_nonzero;
  logic out_last_label;
  logic cfg_we;
  logic [CfgBits-1:0] cfg_active_labels;

  leaf_record_t pending_records [$];
  label_prob_t  expected_probs [$];
  logic [23:0]  bg_product;
  logic [23:0]  label_product [NumLabels];
  logic [CfgBits-1:0] labels_in_use;
  int unsigned  error_count;
  int unsigned  idle_cycles;
  int unsigned  push_idle_pct;
  int unsigned  pop_idle_pct;
  int unsigned  pop_holdoff;
  bit           push_enable;

  forest_leaf_label_probability DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_leaf_total(in_leaf_total), .in_leaf_background(in_leaf_background),
    .in_class_count_0(in_class_count[0]), .in_class_count_1(in_class_count[1]),
    .in_class_count_2(in_class_count[2]), .in_class_count_3(in_class_count[3]),
    .in_class_count_4(in_class_count[4]), .in_class_count_5(in_class_count[5]),
    .in_class_count_6(in_class_count[6]), .in_class_count_7(in_class_count[7]),
    .in_final_tree(in_final_tree), .empty(empty), .pop(pop),
    .out_label_index(out_label_index), .out_probability(out_probability),
    .out_nonzero(out_nonzero), .out_last_label(out_last_label),
    .cfg_we(cfg_we), .cfg_active_labels(cfg_active_labels)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Append to the tail of the pending and expected queues
  task automatic add_pending(leaf_record_t rec);
    pending_records = {pending_records, rec};
  endtask

  task automatic add_expected(label_prob_t prob);
    expected_probs = {expected_probs, prob};
  endtask

  // Leaf fraction in Q1.23, zero for an empty leaf, saturated at one
  function automatic logic [23:0] leaf_fraction(logic [23:0] count, logic [23:0] total);
    logic [47:0] quotient;
    if (total == 0) return '0;
    quotient = {count, 23'b0} / {24'b0, total};
    return (quotient > OneQ) ? OneQ : quotient[23:0];
  endfunction

  function automatic logic [23:0] q_product(logic [23:0] a, logic [23:0] b);
    logic [47:0] full_product;
    full_product = a * b;
    return full_product[46:23];
  endfunction

  // Fold one record into the running products; on the last tree queue results
  task automatic predict_label_probs(leaf_record_t rec);
    int unsigned used;
    logic [31:0] denom;
    logic [55:0] quotient;
    label_prob_t prob;
    bg_product = q_product(bg_product, leaf_fraction(rec.background, rec.total));
    for (int k = 0; k < NumLabels; k++)
      label_product[k] = q_product(label_product[k], leaf_fraction(rec.counts[k], rec.total));
    if (!rec.final_tree) return;
    used = labels_in_use;
    if (used == 0) used = 1;
    if (used > NumLabels) used = NumLabels;
    denom = 32'(bg_product) + 32'd1;
    for (int k = 0; k < used; k++) denom += 32'(label_product[k]);
    for (int k = 0; k < used; k++) begin
      quotient = {label_product[k], 23'b0} / {24'b0, denom};
      prob.label_index = k[LabelBits-1:0];
      prob.probability = quotient[23:0];
      prob.nonzero = (quotient != 0);
      prob.last_label = (k + 1 == used);
      add_expected(prob);
    end
    bg_product = OneQ;
    for (int k = 0; k < NumLabels; k++) label_product[k] = OneQ;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [23:0] rand_count(logic [23:0] total);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CountMax;
      2: return total;
      3: return 24'($urandom);
      default: return (total == 0) ? 24'($urandom_range(0, 15)) :
                      24'($urandom_range(0, total));
    endcase
  endfunction

  function automatic leaf_record_t rand_record(logic is_final);
    leaf_record_t rec;
    case ($urandom_range(0, 9))
      0: rec.total = '0;
      1: rec.total = CountMax;
      2: rec.total = 24'($urandom);
      default: rec.total = 24'($urandom_range(1, 4000));
    endcase
    rec.background = rand_count(rec.total);
    for (int k = 0; k < NumLabels; k++) rec.counts[k] = rand_count(rec.total);
    rec.final_tree = is_final;
    return rec;
  endfunction

  function automatic leaf_record_t fixed_record(logic [23:0] total, logic [23:0] count,
                                               logic is_final);
    leaf_record_t rec;
    rec.total = total;
    rec.background = count;
    for (int k = 0; k < NumLabels; k++) rec.counts[k] = count;
    rec.final_tree = is_final;
    return rec;
  endfunction

  // Push records in order; an empty leaf or count above total stays legal
  task automatic queue_sample(int unsigned trees);
    for (int t = 1; t <= trees; t++) add_pending(rand_record(t == trees));
  endtask

  task automatic drain_and_settle();
    while (pending_records.size() != 0 || expected_probs.size() != 0) @(posedge clk);
    repeat (RecordCycles * 3) @(posedge clk);
  endtask

  // Update the register only while the block is idle
  task automatic write_labels(logic [CfgBits-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_active_labels <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    labels_in_use = value;
  endtask

  // Predict on each input transfer
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      predict_label_probs(pending_records.pop_front());
    end
  end

  // Driver: offer the head record
  always @(negedge clk) begin
    logic offer;
    leaf_record_t head;
    offer = rst_n && push_enable && pending_records.size() != 0 &&
            ($urandom_range(0, 99) >= push_idle_pct);
    push <= offer;
    if (pending_records.size() != 0) begin
      head = pending_records[0];
      in_leaf_total <= head.total;
      in_leaf_background <= head.background;
      for (int k = 0; k < NumLabels; k++) in_class_count[k] <= head.counts[k];
      in_final_tree <= head.final_tree;
    end
  end

  // Receiver: random pops, with a counted hold-off when requested
  always @(negedge clk) begin
    if (pop_holdoff != 0) begin
      pop_holdoff <= pop_holdoff - 1;
      pop <= 1'b0;
    end else begin
      pop <= rst_n && ($urandom_range(0, 99) >= pop_idle_pct);
    end
  end

  // Monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin
    label_prob_t want;
    if (rst_n && pop && !empty) begin
      if (expected_probs.size() == 0) begin
        report_mismatch("unexpected result, label", out_label_index, 0);
      end else begin
        want = expected_probs.pop_front();
        if (out_label_index !== want.label_index)
          report_mismatch("label_index", out_label_index, want.label_index);
        if (out_probability !== want.probability)
          report_mismatch("probability", out_probability, want.probability);
        if (out_nonzero !== want.nonzero)
          report_mismatch("nonzero", out_nonzero, want.nonzero);
        if (out_last_label !== want.last_label)
          report_mismatch("last_label", out_last_label, want.last_label);
      end
    end
  end

  // Watchdog: stop when nothing transfers for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CfgBits-1:0] settings [6];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_active_labels = '0;
    in_leaf_total = '0;
    in_leaf_background = '0;
    for (int k = 0; k < NumLabels; k++) in_class_count[k] = '0;
    in_final_tree = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    pop_holdoff = 0;
    push_enable = 1'b1;
    push_idle_pct = 35;
    pop_idle_pct = 35;
    bg_product = OneQ;
    for (int k = 0; k < NumLabels; k++) label_product[k] = OneQ;
    labels_in_use = 4'd8;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, empty leaves, saturation, single-tree samples
    add_pending(fixed_record(CountMax, CountMax, 1'b1));
    add_pending(fixed_record('0, CountMax, 1'b1));
    add_pending(fixed_record(24'd1, CountMax, 1'b0));
    add_pending(fixed_record(24'd10, 24'd3, 1'b1));
    add_pending(fixed_record(CountMax, '0, 1'b1));
    add_pending(fixed_record(24'd7, 24'd0, 1'b0));
    add_pending(fixed_record(24'd7, 24'd7, 1'b1));
    add_pending(fixed_record(24'h555555, 24'hAAAAAA, 1'b1));
    add_pending(fixed_record(24'hAAAAAA, 24'h555555, 1'b1));
    queue_sample(3);
    queue_sample(1);
    drain_and_settle();

    // Hold off the receiver while records keep coming
    pop_holdoff = 3000;
    for (int s = 0; s < 6; s++) queue_sample(1);
    drain_and_settle();

    // Sweep the register through extremes and out-of-range values
    settings = '{4'd1, 4'd0, 4'd15, 4'd9, 4'd3, 4'd8};
    foreach (settings[i]) begin
      write_labels(settings[i]);
      push_idle_pct = (i == 2) ? 0 : 35;
      pop_idle_pct = (i == 2) ? 0 : 35;
      for (int s = 0; s < 23; s++) queue_sample($urandom_range(1, 5));
      // sender pauses until every expected result has come
      if (i == 3) begin
        while (expected_probs.size() == 0) @(posedge clk);
        push_enable = 1'b0;
        while (expected_probs.size() != 0) @(posedge clk);
        push_enable = 1'b1;
      end
      drain_and_settle();
    end
    push_enable = 1'b1;

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
